// ===== rtl/uart_rx_fifo_flow_control_unit_assert.svh =====
// assertion macros for the checker of the receive fifo
`ifndef UART_RX_FIFO_FLOW_CONTROL_UNIT_ASSERT_SVH
`define UART_RX_FIFO_FLOW_CONTROL_UNIT_ASSERT_SVH

// clocked property, masked while reset is asserted
`define URFC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define URFC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/urfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package urfc_pkg;

	localparam int LEN_W  = 10;
	localparam int FILL_W = 9;
	localparam int DATA_W = 8;
	localparam int CMD_W  = 2;
	localparam int CTL_W  = 2;
	localparam int REG_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LINE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INJECT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	// control state codes
	localparam logic [CTL_W-1:0] CTL_NONE      = 2'd0;
	localparam logic [CTL_W-1:0] CTL_INTERRUPT = 2'd1;
	localparam logic [CTL_W-1:0] CTL_PAUSE     = 2'd2;

	// terminal control characters
	localparam logic [DATA_W-1:0] CH_INTERRUPT = 8'h03;
	localparam logic [DATA_W-1:0] CH_PAUSE     = 8'h1A;

	// register indexes
	localparam logic [REG_W-1:0] REG_BUFFER_LENGTH = 2'd0;
	localparam logic [REG_W-1:0] REG_FLOW_LIMIT    = 2'd1;
	localparam logic [REG_W-1:0] REG_TERMINAL_MODE = 2'd2;
	localparam logic [REG_W-1:0] REG_FLOW_CTRL_EN  = 2'd3;

	// register reset values
	localparam logic [LEN_W-1:0] LEN_RESET   = 10'd512;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 10'd448;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              read_valid;
		logic              interrupted;
		logic              paused;
		logic              dropped;
		logic [FILL_W-1:0] fill_count;
		logic              rts_ready;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/urfc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface urfc_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [urfc_pkg::CMD_W-1:0]  command;
	logic [urfc_pkg::DATA_W-1:0] data_byte;
	logic                        line_error;

	modport source (output valid, output command, output data_byte, output line_error,
		input ready);
	modport sink (input valid, input command, input data_byte, input line_error,
		output ready);
endinterface

interface urfc_res_if;
	logic                        valid;
	logic                        ready;
	logic [urfc_pkg::DATA_W-1:0] read_data;
	logic                        read_valid;
	logic                        interrupted;
	logic                        paused;
	logic                        dropped;
	logic [urfc_pkg::FILL_W-1:0] fill_count;
	logic                        rts_ready;

	modport source (output valid, output read_data, output read_valid, output interrupted,
		output paused, output dropped, output fill_count, output rts_ready, input ready);
	modport sink (input valid, input read_data, input read_valid, input interrupted,
		input paused, input dropped, input fill_count, input rts_ready, output ready);
endinterface

`default_nettype wire

// ===== rtl/uart_rx_fifo_flow_control_unit.sv =====
// results: a read that pops a byte passes through the byte store read port, then the result
// queue; every other command's result enters the result queue directly
// throughput: one command per cycle while the result queue is not full; a popping read holds
// off the next command while the byte store read port returns its data; a two-entry result queue decouples
// reset: indices, ready flag, control state and registers go to defaults at once;
// the byte store is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_fifo_flow_control_unit #(
	parameter int BUFFER_DEPTH = 512
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [urfc_pkg::REG_W-1:0] cfg_index,
	input  wire logic [urfc_pkg::LEN_W-1:0] cfg_wdata,
	urfc_cmd_if.sink                        cmd_ch,
	urfc_res_if.source                      res_ch
);

	localparam int AW  = $clog2(BUFFER_DEPTH);
	localparam int NW  = AW + 1;
	localparam int LCW = (NW > urfc_pkg::LEN_W) ? NW : urfc_pkg::LEN_W;
	localparam logic [LCW-1:0] DEPTH_L = LCW'(BUFFER_DEPTH);
	localparam logic [LCW-1:0] LEN_MIN = LCW'(2);
	localparam logic [NW-1:0]  N_RESET =
		(LCW'(urfc_pkg::LEN_RESET) > DEPTH_L) ? NW'(BUFFER_DEPTH) : NW'(urfc_pkg::LEN_RESET);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                       state_q;
	logic [NW-1:0]                n_q;
	logic [urfc_pkg::LEN_W-1:0]   limit_q;
	logic                         term_q;
	logic                         fce_q;
	logic [AW-1:0]                w_q;
	logic [AW-1:0]                r_q;
	logic                         ready_q;
	logic [urfc_pkg::CTL_W-1:0]   ctl_q;
	urfc_pkg::res_t               pend_s1;

	logic [LCW-1:0]               len_ext;
	logic [NW-1:0]                n_cfg;
	logic [NW-1:0]                fill;
	logic [NW-1:0]                fill_after;
	logic                         full;
	logic                         accept;
	logic                         store_ok;
	logic                         pop;
	logic                         dropped;
	logic                         ready_d;
	logic [urfc_pkg::CTL_W-1:0]   ctl_d;
	logic [NW-1:0]                w_inc;
	logic [NW-1:0]                r_inc;
	logic [AW-1:0]                w_next;
	logic [AW-1:0]                r_next;
	urfc_pkg::res_t               res_now;
	urfc_pkg::res_t               push_data;
	logic                         push;
	logic [urfc_pkg::DATA_W-1:0]  mem_rdata;
	urfc_pkg::res_t               q_head;
	logic                         q_valid;
	logic                         q_full;

	// ring length clamped to the usable range
	assign len_ext = LCW'(cfg_wdata);
	always_comb begin
		if (len_ext < LEN_MIN) begin
			n_cfg = NW'(2);
		end else if (len_ext > DEPTH_L) begin
			n_cfg = NW'(BUFFER_DEPTH);
		end else begin
			n_cfg = NW'(len_ext);
		end
	end

	assign fill = (w_q >= r_q) ? (NW'(w_q) - NW'(r_q)) : (n_q - (NW'(r_q) - NW'(w_q)));
	assign full = (fill >= (n_q - NW'(1)));

	assign w_inc  = NW'(w_q) + NW'(1);
	assign r_inc  = NW'(r_q) + NW'(1);
	assign w_next = (w_inc >= n_q) ? '0 : w_inc[AW-1:0];
	assign r_next = (r_inc >= n_q) ? '0 : r_inc[AW-1:0];

	assign cmd_ch.ready = (state_q == ST_IDLE) && !q_full;
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	always_comb begin
		ctl_d    = ctl_q;
		ready_d  = ready_q;
		store_ok = 1'b0;
		pop      = 1'b0;
		dropped  = 1'b0;
		case (cmd_ch.command)
			urfc_pkg::CMD_LINE: begin
				if (cmd_ch.line_error) begin
					dropped = 1'b1;
				end else begin
					store_ok = !full;
					dropped  = full;
					// control detection applies even when the byte is lost to a full ring
					if (term_q) begin
						if (cmd_ch.data_byte == urfc_pkg::CH_INTERRUPT) begin
							ctl_d = urfc_pkg::CTL_INTERRUPT;
						end else if (cmd_ch.data_byte == urfc_pkg::CH_PAUSE) begin
							ctl_d = (ctl_q != urfc_pkg::CTL_PAUSE) ? urfc_pkg::CTL_PAUSE
								: urfc_pkg::CTL_NONE;
						end
					end
				end
			end
			urfc_pkg::CMD_INJECT: begin
				store_ok = !full;
				dropped  = full;
			end
			urfc_pkg::CMD_READ: begin
				if (LCW'(fill) < LCW'(limit_q)) begin
					ready_d = 1'b1;
				end
				pop = (fill != '0);
			end
			urfc_pkg::CMD_CLEAR: begin
				ctl_d = urfc_pkg::CTL_NONE;
			end
			default: begin
			end
		endcase

		if (store_ok) begin
			fill_after = fill + NW'(1);
		end else if (pop) begin
			fill_after = fill - NW'(1);
		end else begin
			fill_after = fill;
		end

		if (store_ok && (LCW'(fill_after) >= LCW'(limit_q))) begin
			ready_d = 1'b0;
		end

		res_now.read_data   = '0;
		res_now.read_valid  = pop;
		res_now.interrupted = (ctl_d == urfc_pkg::CTL_INTERRUPT);
		res_now.paused      = (ctl_d == urfc_pkg::CTL_PAUSE);
		res_now.dropped     = dropped;
		res_now.fill_count  = urfc_pkg::FILL_W'(fill_after);
		res_now.rts_ready   = fce_q ? ready_d : 1'b1;
	end

	urfc_mem #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (accept && store_ok),
		.waddr (w_q),
		.wdata (cmd_ch.data_byte),
		.re    (accept && pop),
		.raddr (r_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= N_RESET;
			limit_q <= urfc_pkg::LIMIT_RESET;
			term_q  <= 1'b0;
			fce_q   <= 1'b1;
			w_q     <= '0;
			r_q     <= '0;
			ready_q <= 1'b1;
			ctl_q   <= urfc_pkg::CTL_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && pop) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (accept) begin
				if (store_ok) begin
					w_q <= w_next;
				end
				if (pop) begin
					r_q <= r_next;
				end
				ready_q <= ready_d;
				ctl_q   <= ctl_d;
			end

			if (cfg_we) begin
				case (cfg_index)
					urfc_pkg::REG_BUFFER_LENGTH: begin
						// new length empties the ring
						n_q     <= n_cfg;
						w_q     <= '0;
						r_q     <= '0;
						ready_q <= 1'b1;
					end
					urfc_pkg::REG_FLOW_LIMIT: begin
						limit_q <= cfg_wdata;
					end
					urfc_pkg::REG_TERMINAL_MODE: begin
						term_q <= cfg_wdata[0];
					end
					urfc_pkg::REG_FLOW_CTRL_EN: begin
						fce_q <= cfg_wdata[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result fields of a popping read wait here for the store data
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_s1 <= res_now;
		end
	end

	assign push = (accept && !pop) || (state_q == ST_READ);

	always_comb begin
		if (state_q == ST_READ) begin
			push_data           = pend_s1;
			push_data.read_data = mem_rdata;
		end else begin
			push_data = res_now;
		end
	end

	urfc_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop_ready  (res_ch.ready),
		.head       (q_head),
		.head_valid (q_valid),
		.full       (q_full)
	);

	assign res_ch.valid       = q_valid;
	assign res_ch.read_data   = q_head.read_data;
	assign res_ch.read_valid  = q_head.read_valid;
	assign res_ch.interrupted = q_head.interrupted;
	assign res_ch.paused      = q_head.paused;
	assign res_ch.dropped     = q_head.dropped;
	assign res_ch.fill_count  = q_head.fill_count;
	assign res_ch.rts_ready   = q_head.rts_ready;

endmodule

`default_nettype wire

// ===== rtl/urfc_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urfc_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [urfc_pkg::DATA_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [urfc_pkg::DATA_W-1:0] rdata
);

	logic [urfc_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/urfc_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urfc_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire urfc_pkg::res_t push_data,
	input  wire logic           pop_ready,
	output urfc_pkg::res_t      head,
	output logic                head_valid,
	output logic                full
);

	urfc_pkg::res_t head_q;
	urfc_pkg::res_t tail_q;
	logic           head_v_q;
	logic           tail_v_q;
	logic           pop;

	assign pop        = head_v_q & pop_ready;
	assign head       = head_q;
	assign head_valid = head_v_q;
	assign full       = tail_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (pop) begin
			head_v_q <= tail_v_q | push;
			tail_v_q <= tail_v_q & push;
		end else if (push) begin
			head_v_q <= 1'b1;
			tail_v_q <= head_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= tail_v_q ? tail_q : push_data;
			if (push) begin
				tail_q <= push_data;
			end
		end else if (push) begin
			if (head_v_q) begin
				tail_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/urfc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "uart_rx_fifo_flow_control_unit_assert.svh"

module urfc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cmd_valid,
	input wire logic                        cmd_ready,
	input wire logic                        res_valid,
	input wire logic                        res_ready,
	input wire logic [urfc_pkg::DATA_W-1:0] read_data,
	input wire logic                        read_valid,
	input wire logic                        interrupted,
	input wire logic                        paused,
	input wire logic                        dropped,
	input wire logic [urfc_pkg::FILL_W-1:0] fill_count,
	input wire logic                        rts_ready
);

	// commands taken whose results have not been transferred yet
	logic [1:0] outstanding_q;
	logic       cmd_xfer;
	logic       res_xfer;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign res_xfer = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 2'd0;
		end else if (cmd_xfer && !res_xfer) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (res_xfer && !cmd_xfer) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	`URFC_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !res_valid,
		"result offered during reset")

	`URFC_ASSERT(a_no_spurious_result, clk, arst_n,
		res_valid |-> (outstanding_q != 2'd0), "result offered with no command pending")

	`URFC_ASSERT(a_no_overrun, clk, arst_n,
		(outstanding_q == 2'd2) |-> !cmd_ready, "command taken with result queue committed")

	`URFC_ASSERT(a_stall_holds, clk, arst_n,
		res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(read_valid)
			&& $stable(interrupted) && $stable(paused) && $stable(dropped)
			&& $stable(fill_count) && $stable(rts_ready),
		"stalled result changed")

endmodule

bind uart_rx_fifo_flow_control_unit urfc_checker u_urfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_ch.valid),
	.cmd_ready   (cmd_ch.ready),
	.res_valid   (res_ch.valid),
	.res_ready   (res_ch.ready),
	.read_data   (res_ch.read_data),
	.read_valid  (res_ch.read_valid),
	.interrupted (res_ch.interrupted),
	.paused      (res_ch.paused),
	.dropped     (res_ch.dropped),
	.fill_count  (res_ch.fill_count),
	.rts_ready   (res_ch.rts_ready)
);

`default_nettype wire
